[rtl/tcw_pkg.sv]
// Shared definitions for the text console writer: screen geometry, character
// and mode codes, controller states and the command and status bundles.
// No dependencies.
`default_nettype none

package tcw_pkg;

    // Screen geometry.
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int TAB_STOP      = 8;

    // Internal widths: the row may pass the last row by one before it settles,
    // and a tab may push the column to one past the last column before it wraps.
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 2);
    localparam int COL_W  = $clog2(SCREEN_WIDTH + TAB_STOP);

    // Field widths of the ports.
    localparam int MODE_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int RROW_W = 5;
    localparam int RCOL_W = 7;

    // Last cell index of the row move during a scroll, and of the whole store.
    localparam int MOVE_LAST = SCREEN_WIDTH * (SCREEN_HEIGHT - 1) - 1;
    localparam int CELL_LAST = CELL_COUNT - 1;

    // Character and attribute codes.
    localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;
    localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_ATTR, CHAR_BLANK};

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_WRITE,
        ST_CHECK,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL_BOTTOM,
        ST_FILL_ALL,
        ST_READ,
        ST_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;    // capture the incoming request
        logic cur_step;    // store the character and advance the cursor
        logic scroll_rd;   // read the cell one row below the index
        logic scroll_wr;   // write the read cell at the index
        logic fill_wr;     // write a blank at the index
        logic reset_blank; // fill with the reset blank instead of the current one
        logic idx_inc;     // advance the cell index
        logic idx_clear;   // return the cell index to zero
        logic row_dec;     // one row scrolled away
        logic home;        // cursor to the top left corner
        logic rd_cell;     // read the requested cell
        logic out_load;    // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_move;
        logic last_cell;
        logic row_over;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/tcw_ctrl.sv]
// Controller of the text console writer: sequences the reset clearing pass,
// character writes, scrolls, clears, reads and result delivery.
// Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [MODE_W-1:0] i_in_mode,
    input  wire t_dp_status        i_status,
    output t_dp_cmd                o_cmd,
    output logic                   o_in_stall
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (i_status.last_cell) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_mode)
                        MODE_WRITE: n_state = ST_WRITE;
                        MODE_CLEAR: n_state = ST_FILL_ALL;
                        MODE_READ:  n_state = ST_READ;
                        default:    n_state = ST_RESULT;
                    endcase
                end
            end
            ST_WRITE:     n_state = ST_CHECK;
            ST_CHECK:     n_state = i_status.row_over ? ST_SCROLL_RD : ST_RESULT;
            ST_SCROLL_RD: n_state = ST_SCROLL_WR;
            ST_SCROLL_WR: n_state = i_status.last_move ? ST_FILL_BOTTOM : ST_SCROLL_RD;
            ST_FILL_BOTTOM: begin
                if (i_status.last_cell) n_state = ST_CHECK;
            end
            ST_FILL_ALL: begin
                if (i_status.last_cell) n_state = ST_RESULT;
            end
            ST_READ: n_state = ST_RESULT;
            ST_RESULT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.fill_wr     = 1'b1;
                o_cmd.reset_blank = 1'b1;
                o_cmd.idx_inc     = !i_status.last_cell;
                o_cmd.idx_clear   = i_status.last_cell;
            end
            ST_IDLE: begin
                o_cmd.load_req = i_in_valid;
            end
            ST_WRITE: begin
                o_cmd.cur_step = 1'b1;
            end
            ST_CHECK: begin
            end
            ST_SCROLL_RD: begin
                o_cmd.scroll_rd = 1'b1;
            end
            ST_SCROLL_WR: begin
                o_cmd.scroll_wr = 1'b1;
                o_cmd.idx_inc   = 1'b1;
            end
            ST_FILL_BOTTOM: begin
                o_cmd.fill_wr   = 1'b1;
                o_cmd.idx_inc   = !i_status.last_cell;
                o_cmd.idx_clear = i_status.last_cell;
                o_cmd.row_dec   = i_status.last_cell;
            end
            ST_FILL_ALL: begin
                o_cmd.fill_wr   = 1'b1;
                o_cmd.idx_inc   = !i_status.last_cell;
                o_cmd.idx_clear = i_status.last_cell;
                o_cmd.home      = i_status.last_cell;
            end
            ST_READ: begin
                o_cmd.rd_cell = 1'b1;
            end
            ST_RESULT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

[rtl/tcw_datapath.sv]
// Datapath of the text console writer: screen memory, cursor, attribute,
// cell index for scroll and fill passes, request and result registers.
// Depends on tcw_pkg.
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    input  wire logic              i_cfg_valid,
    input  wire logic [ATTR_W-1:0] i_cfg_data,
    input  wire logic [MODE_W-1:0] i_in_mode,
    input  wire logic [CHAR_W-1:0] i_in_character,
    input  wire logic [RROW_W-1:0] i_in_read_row,
    input  wire logic [RCOL_W-1:0] i_in_read_col,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic [CELL_W-1:0]      o_out_cell_data,
    output logic [RROW_W-1:0]      o_out_cursor_row,
    output logic [RCOL_W-1:0]      o_out_cursor_col
);

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rd_data;

    logic [ATTR_W-1:0] r_attr;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ADDR_W-1:0] r_idx;

    logic [MODE_W-1:0] r_req_mode;
    logic [CHAR_W-1:0] r_req_char;
    logic [RROW_W-1:0] r_req_row;
    logic [RCOL_W-1:0] r_req_col;

    logic              r_out_valid;
    logic [CELL_W-1:0] r_out_data;
    logic [RROW_W-1:0] r_out_row;
    logic [RCOL_W-1:0] r_out_col;

    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  w_row_a;
    logic [COL_W-1:0]  w_col_a;
    logic [COL_W-1:0]  w_col_inc;
    logic [COL_W-1:0]  w_col_tab;
    logic              w_is_newline;
    logic              w_req_in_range;
    logic [ADDR_W-1:0] w_cur_addr;
    logic [ADDR_W-1:0] w_req_addr;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [CELL_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_out_free;

    // Attribute register; writes must arrive only while the block is idle (the block itself does not enforce this).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_mode <= i_in_mode;
            r_req_char <= i_in_character;
            r_req_row  <= i_in_read_row;
            r_req_col  <= i_in_read_col;
        end
    end

    // Cursor advance after a stored character: one column, wrap at the line
    // end, and for a tab on to the next tab stop with a second wrap.
    always_comb begin
        w_col_inc = r_col + COL_W'(1);
        if (32'(w_col_inc) >= SCREEN_WIDTH) begin
            w_col_a = '0;
            w_row_a = r_row + ROW_W'(1);
        end else begin
            w_col_a = w_col_inc;
            w_row_a = r_row;
        end
        w_col_tab = (w_col_a & ~COL_W'(TAB_STOP - 1)) + COL_W'(TAB_STOP);
        n_col = w_col_a;
        n_row = w_row_a;
        if (r_req_char == CHAR_TAB) begin
            if (32'(w_col_tab) >= SCREEN_WIDTH) begin
                n_col = '0;
                n_row = w_row_a + ROW_W'(1);
            end else begin
                n_col = w_col_tab;
            end
        end
    end

    assign w_is_newline = (r_req_char == CHAR_NEWLINE);

    // Cursor registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.home) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.row_dec) begin
            r_row <= r_row - ROW_W'(1);
        end else if (i_cmd.cur_step) begin
            if (w_is_newline) begin
                r_row <= r_row + ROW_W'(1);
                r_col <= '0;
            end else begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    // Cell index for scroll and fill passes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clear) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + ADDR_W'(1);
        end
    end

    // Cell addresses.
    assign w_cur_addr = ADDR_W'(r_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(r_col);
    assign w_req_addr = ADDR_W'(r_req_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(r_req_col);
    assign w_req_in_range = (32'(r_req_row) < SCREEN_HEIGHT) &&
                            (32'(r_req_col) < SCREEN_WIDTH);

    // Memory write port selection.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = {r_attr, CHAR_BLANK};
        priority if (i_cmd.cur_step) begin
            w_wr_en   = !w_is_newline;
            w_wr_addr = w_cur_addr;
            w_wr_data = {r_attr, r_req_char};
        end else if (i_cmd.scroll_wr) begin
            w_wr_en   = 1'b1;
            w_wr_data = r_rd_data;
        end else if (i_cmd.fill_wr) begin
            w_wr_en   = 1'b1;
            w_wr_data = i_cmd.reset_blank ? RESET_BLANK : {r_attr, CHAR_BLANK};
        end else begin
            w_wr_en = 1'b0;
        end
    end

    // Memory read port selection: the row below during a scroll, or the cell
    // that a read request names.
    assign w_rd_en   = i_cmd.scroll_rd || i_cmd.rd_cell;
    assign w_rd_addr = i_cmd.scroll_rd ? (r_idx + ADDR_W'(SCREEN_WIDTH)) : w_req_addr;

    // Screen memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Result register; it takes a new result only once the last one is gone.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= (r_req_mode == MODE_READ && w_req_in_range) ? r_rd_data : '0;
            r_out_row  <= RROW_W'(r_row);
            r_out_col  <= RCOL_W'(r_col);
        end
    end

    // Status for the controller.
    assign o_status.last_move = (r_idx == ADDR_W'(MOVE_LAST));
    assign o_status.last_cell = (r_idx == ADDR_W'(CELL_LAST));
    assign o_status.row_over  = (32'(r_row) >= SCREEN_HEIGHT);
    assign o_status.out_free  = w_out_free;

    assign o_out_valid      = r_out_valid;
    assign o_out_cell_data  = r_out_data;
    assign o_out_cursor_row = r_out_row;
    assign o_out_cursor_col = r_out_col;

`ifndef SYNTHESIS
    // A result is reported only with the cursor settled on the screen.
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (32'(r_row) < SCREEN_HEIGHT) && (32'(r_col) < SCREEN_WIDTH))
        else $error("cursor off screen when a result is loaded");

    // Only one source drives the memory write port in a cycle.
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.cur_step, i_cmd.scroll_wr, i_cmd.fill_wr}))
        else $error("more than one memory write source");

    // A scroll read is always followed by the write of the cell it fetched.
    a_scroll_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scroll_rd |=> i_cmd.scroll_wr)
        else $error("scroll read not followed by its write");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

[rtl/text_console_writer.sv]
// Text console writer: a screen of SCREEN_HEIGHT rows by SCREEN_WIDTH columns
// of 16-bit cells (attribute high byte, character low byte) with a cursor.
// Every request (write character, clear, read cell) returns one result with
// the cell read (zero unless a read in range) and the cursor after the step.
// After reset the block runs a clearing pass over all CELL_COUNT cells (2000
// at 80 x 25) before it takes the first request; attribute writes are accepted
// at any time. A character write that passes the last row adds one scroll
// per row, in which each cell moves as a read (ST_SCROLL_RD) followed by a
// write (ST_SCROLL_WR), and then a fill of the bottom row. A clear writes one
// blank per cycle, and a read goes through the registered memory read.
// Requests are handled one at a time; the next request is accepted while the
// previous result still waits in the output register.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [ATTR_W-1:0] i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [MODE_W-1:0] i_in_mode,
    input  wire logic [CHAR_W-1:0] i_in_character,
    input  wire logic [RROW_W-1:0] i_in_read_row,
    input  wire logic [RCOL_W-1:0] i_in_read_col,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [CELL_W-1:0]      o_out_cell_data,
    output logic [RROW_W-1:0]      o_out_cursor_row,
    output logic [RCOL_W-1:0]      o_out_cursor_col
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // The attribute register is always able to take a write.
    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_mode),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    tcw_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_in_mode        (i_in_mode),
        .i_in_character   (i_in_character),
        .i_in_read_row    (i_in_read_row),
        .i_in_read_col    (i_in_read_col),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_cell_data  (o_out_cell_data),
        .o_out_cursor_row (o_out_cursor_row),
        .o_out_cursor_col (o_out_cursor_col)
    );

endmodule

`default_nettype wire
